FILE: rtl/fixed_point_alu_q24_8_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Q24.8 fixed-point ALU
// Property forms used by fixed_point_alu_q24_8.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FPA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition holds at every edge out of reset
`define FPA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

`endif

FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Commands, widths and defaults of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned FRACTION_DEF  = 8;
	localparam int unsigned DIV_STEPS     = 4;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_GT       = 4'd4,
		CMD_LT       = 4'd5,
		CMD_GE       = 4'd6,
		CMD_LE       = 4'd7,
		CMD_EQ       = 4'd8,
		CMD_NE       = 4'd9,
		CMD_INC      = 4'd10,
		CMD_DEC      = 4'd11,
		CMD_MIN      = 4'd12,
		CMD_MAX      = 4'd13,
		CMD_FROM_INT = 4'd14,
		CMD_TO_INT   = 4'd15
	} cmd_t;

endpackage

FILE: rtl/fpa_req_if.sv
// ----------------------------------------------------------------------------
// fpa_req_if
// Request channel: command and two raw operands.
// ----------------------------------------------------------------------------
interface fpa_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         command;
	logic signed [31:0] lhs_raw;
	logic signed [31:0] rhs_raw;

	modport source (output valid, output command, output lhs_raw, output rhs_raw, input ready);
	modport sink   (input valid, input command, input lhs_raw, input rhs_raw, output ready);
endinterface

FILE: rtl/fpa_rsp_if.sv
// ----------------------------------------------------------------------------
// fpa_rsp_if
// Response channel: result word and status flags.
// ----------------------------------------------------------------------------
interface fpa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_raw;
	logic               compare_true;
	logic               divide_by_zero;

	modport source (output valid, output result_raw, output compare_true,
		output divide_by_zero, input ready);
	modport sink   (input valid, input result_raw, input compare_true,
		input divide_by_zero, output ready);
endinterface

FILE: rtl/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed fixed-point ALU, pipelined, one transfer per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Takes one command every cycle and returns one result per command, in order.
// The pipeline depth is set by the restoring divider, which resolves four
// quotient bits per stage. Multiply uses one 32x32 multiplier in the first
// divider stage. All commands share the same pipeline, so throughput is one
// item per cycle; a stalled output freezes the whole pipeline.
module fixed_point_alu_q24_8 #(
	parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fpa_req_if.sink   in_ch,
	fpa_rsp_if.source out_ch
);
	import fpa_pkg::*;
	`include "fixed_point_alu_q24_8_defines.svh"

	localparam int unsigned NQ   = WORD_W + FRACTION_BITS;
	localparam int unsigned NSTG = (NQ + DIV_STEPS - 1) / DIV_STEPS;

	typedef struct packed {
		cmd_t                cmd;
		logic [WORD_W-1:0]   ua;
		logic                neg;
		logic [2*WORD_W-1:0] prod;
		logic [WORD_W:0]     rem;
		logic [NQ-1:0]       num;
		logic [NQ-1:0]       quo;
		logic [WORD_W-1:0]   dvs;
		logic [WORD_W-1:0]   res;
		logic                cmp;
		logic                dz;
	} stage_t;

	stage_t stg_s [0:NSTG];
	logic   vld_s [0:NSTG];
	logic   en;

	logic [WORD_W-1:0] res_q;
	logic              cmp_q;
	logic              dz_q;
	logic              out_vld_q;

	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// ---- stage 0: operand capture and simple commands
	stage_t in_st;
	always_comb begin
		logic signed [WORD_W-1:0] a;
		logic signed [WORD_W-1:0] b;
		logic [WORD_W-1:0] ma;
		logic [WORD_W-1:0] mb;
		a  = in_ch.lhs_raw;
		b  = in_ch.rhs_raw;
		ma = a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
		mb = b[WORD_W-1] ? (~b + WORD_W'(1)) : b;
		in_st      = '0;
		in_st.cmd  = cmd_t'(in_ch.command);
		in_st.ua   = a;
		in_st.neg  = a[WORD_W-1] ^ b[WORD_W-1];
		in_st.num  = {ma, {FRACTION_BITS{1'b0}}};
		in_st.dvs  = mb;
		case (cmd_t'(in_ch.command))
			CMD_ADD:      in_st.res = a + b;
			CMD_SUB:      in_st.res = a - b;
			CMD_GT:       in_st.cmp = a > b;
			CMD_LT:       in_st.cmp = a < b;
			CMD_GE:       in_st.cmp = a >= b;
			CMD_LE:       in_st.cmp = a <= b;
			CMD_EQ:       in_st.cmp = a == b;
			CMD_NE:       in_st.cmp = a != b;
			CMD_INC:      in_st.res = a + WORD_W'(1);
			CMD_DEC:      in_st.res = a - WORD_W'(1);
			CMD_MIN:      in_st.res = (a < b) ? a : b;
			CMD_MAX:      in_st.res = (a > b) ? a : b;
			CMD_FROM_INT: in_st.res = a << FRACTION_BITS;
			CMD_TO_INT:   in_st.res = a >>> FRACTION_BITS;
			CMD_DIV:      in_st.dz  = (b == '0);
			default:      in_st.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= in_st;
		end
	end

	// ---- divider stages, multiply in the first
	for (genvar k = 1; k <= NSTG; k++) begin : g_div
		stage_t nxt;
		always_comb begin
			logic [WORD_W:0] r;
			nxt = stg_s[k-1];
			if (k == 1) begin
				nxt.prod = stg_s[0].num[NQ-1:FRACTION_BITS] * stg_s[0].dvs;
			end
			r = nxt.rem;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if ((k - 1) * DIV_STEPS + j < NQ) begin
					r        = {r[WORD_W-1:0], nxt.num[NQ-1]};
					nxt.num  = nxt.num << 1;
					if (r >= {1'b0, nxt.dvs}) begin
						r       = r - {1'b0, nxt.dvs};
						nxt.quo = {nxt.quo[NQ-2:0], 1'b1};
					end else begin
						nxt.quo = {nxt.quo[NQ-2:0], 1'b0};
					end
				end
			end
			nxt.rem = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k] <= nxt;
			end
		end
	end

	// ---- rounding, sign and result select
	logic [WORD_W-1:0] mul_mag;
	logic [WORD_W-1:0] div_mag;
	logic [WORD_W-1:0] fin_res;
	always_comb begin
		stage_t  l;
		logic    rnd;
		l       = stg_s[NSTG];
		mul_mag = l.prod[FRACTION_BITS+WORD_W-1:FRACTION_BITS]
			+ {{(WORD_W-1){1'b0}}, l.prod[FRACTION_BITS-1]};
		rnd     = ({l.rem, 1'b0} >= {2'b00, l.dvs});
		div_mag = l.quo[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, rnd};
		case (l.cmd)
			CMD_MUL: fin_res = l.neg ? (~mul_mag + WORD_W'(1)) : mul_mag;
			CMD_DIV: fin_res = l.dz ? l.ua : (l.neg ? (~div_mag + WORD_W'(1)) : div_mag);
			default: fin_res = l.res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fin_res;
			cmp_q <= stg_s[NSTG].cmp;
			dz_q  <= stg_s[NSTG].dz;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.result_raw     = res_q;
	assign out_ch.compare_true   = cmp_q;
	assign out_ch.divide_by_zero = dz_q;

	`FPA_ASSERT_IMPLIES(a_cmp_zero_res, clk, arst_n, out_vld_q && cmp_q, res_q == '0)
	`FPA_ASSERT_IMPLIES(a_flags_excl, clk, arst_n, out_vld_q, !(cmp_q && dz_q))
	`FPA_ASSERT_ALWAYS(a_stall_blocks_in, clk, arst_n, in_ch.ready == (!out_vld_q || out_ch.ready))

endmodule
